// ===== rtl/ulam_spiral_prime_walker_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ULAM_SPIRAL_PRIME_WALKER_UNIT_MACROS_SVH
`define ULAM_SPIRAL_PRIME_WALKER_UNIT_MACROS_SVH
// An implication checked at every clock edge outside reset.
`define USPW_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// An implication checked in the cycle after the antecedent.
`define USPW_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/uspw_pkg.sv =====
package uspw_pkg;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned RUN_W   = 11;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 1'd1;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COORD_W-1:0] coord_t;
    // Request and response between the top level and the primality tester.
    typedef struct packed {
        logic   start;
        value_t value;
    } prime_req_t;
    typedef struct packed {
        logic done;
        logic prime;
    } prime_rsp_t;
endpackage

// ===== rtl/uspw_divider.sv =====
// Restoring remainder unit: one quotient bit per cycle.
module uspw_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  uspw_pkg::value_t dividend,
    input  uspw_pkg::value_t divisor,
    output logic             done,
    output logic             rem_zero
);
    import uspw_pkg::*;

    localparam int unsigned CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W:0]   rem_reg, rem_next;
    value_t             quo_reg, quo_next;
    value_t             dsr_reg, dsr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [VALUE_W:0]   shifted;
    logic [VALUE_W:0]   diff;

    // One shift and trial subtract per cycle while busy.
    always_comb begin
        shifted   = {rem_reg[VALUE_W-1:0], quo_reg[VALUE_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(VALUE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[VALUE_W] ? shifted : diff;
            quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);
endmodule

// ===== rtl/uspw_prime_seq.sv =====
// Trial-division sequencer driving its own remainder unit.
module uspw_prime_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  uspw_pkg::prime_req_t req,
    output uspw_pkg::prime_rsp_t rsp
);
    import uspw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ_MUL, S_SQ_CMP, S_DIV_START, S_DIV_WAIT, S_DONE
    } state_t;

    // The candidate never passes the square root of a 32-bit value by more than six,
    // so 18 bits hold it and its square fits in 36 bits.
    state_t         state_reg;
    value_t         num_reg;
    logic [17:0]    cand_reg;
    logic [35:0]    sq_reg;
    logic           plus2_reg;
    logic           prime_reg;
    logic           div_start;
    logic           div_done;
    logic           div_zero;
    value_t         divisor;

    assign divisor   = {14'd0, cand_reg};
    assign div_start = (state_reg == S_DIV_START);

    uspw_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (divisor),
        .done     (div_done),
        .rem_zero (div_zero)
    );

    // Divisors run 2, 3, then 5, 7, 11, 13 ... while the square stays in range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            prime_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        num_reg   <= req.value;
                        if (req.value < 32'd4) begin
                            prime_reg <= (req.value > 32'd1);
                            state_reg <= S_DONE;
                        end else begin
                            prime_reg <= 1'b1;
                            cand_reg  <= 18'd2;
                            plus2_reg <= 1'b0;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_SQ_MUL: begin
                    sq_reg    <= cand_reg * cand_reg;
                    state_reg <= S_SQ_CMP;
                end
                S_SQ_CMP: begin
                    if (sq_reg > {4'd0, num_reg}) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (div_zero) begin
                            prime_reg <= 1'b0;
                            state_reg <= S_DONE;
                        end else if (cand_reg == 18'd2) begin
                            cand_reg  <= 18'd3;
                            state_reg <= S_DIV_START;
                        end else if (cand_reg == 18'd3) begin
                            cand_reg  <= 18'd5;
                            plus2_reg <= 1'b1;
                            state_reg <= S_SQ_MUL;
                        end else if (plus2_reg) begin
                            cand_reg  <= cand_reg + 18'd2;
                            plus2_reg <= 1'b0;
                            state_reg <= S_DIV_START;
                        end else begin
                            cand_reg  <= cand_reg + 18'd4;
                            plus2_reg <= 1'b1;
                            state_reg <= S_SQ_MUL;
                        end
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = (state_reg == S_DONE);
    assign rsp.prime = prime_reg;
endmodule

// ===== rtl/ulam_spiral_prime_walker_unit.sv =====
// Channel | Direction | Ports
// input   | in        | s_valid, s_ready, s_restart
// result  | out       | m_valid, m_ready, m_cell_x, m_cell_y, m_cell_value, m_is_prime, m_last
// config  | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
// An item producing a result runs one remainder-unit division per trial divisor,
// so a large prime, which tries every divisor up to its square root, takes longest.
// An item that produces no result passes from idle through the move state back to idle.
// Reset is synchronous, active low; the walk is idle after reset.
// The block takes no new word while one is in work or a result waits.
module ulam_spiral_prime_walker_unit #(
    parameter int unsigned GRID_MAX = 1023
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [uspw_pkg::COORD_W-1:0]      m_cell_x,
    output logic [uspw_pkg::COORD_W-1:0]      m_cell_y,
    output logic [uspw_pkg::VALUE_W-1:0]      m_cell_value,
    output logic                              m_is_prime,
    output logic                              m_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uspw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uspw_pkg::VALUE_W-1:0]      cfg_data
);
    import uspw_pkg::*;

    localparam int unsigned GM = (GRID_MAX > 1023) ? 1023 : GRID_MAX;
    localparam logic [COORD_W-1:0] GRID_LIM = COORD_W'(GM);

    typedef enum logic [1:0] {S_IDLE, S_MOVE, S_TEST, S_OUT} state_t;

    state_t             state_reg;
    logic [COORD_W-1:0] grid_reg;
    value_t             startv_reg;
    coord_t             px_reg, py_reg;
    logic [1:0]         head_reg;
    logic [RUN_W-1:0]   rlen_reg, rprog_reg;
    value_t             nval_reg;
    logic               active_reg;
    logic               restart_reg;
    value_t             oval_reg;
    logic               oprime_reg;
    logic               olast_reg;
    prime_req_t         preq;
    prime_rsp_t         prsp;
    logic [COORD_W-1:0] side;
    logic [COORD_W:0]   tx, ty;
    logic               tgt_in;
    logic [RUN_W-1:0]   prog_inc;

    // Effective side length and the next target cell.
    always_comb begin
        side = ((grid_reg > GRID_LIM) ? GRID_LIM : grid_reg) | COORD_W'(1);
        tx = {1'b0, px_reg};
        ty = {1'b0, py_reg};
        unique case (head_reg)
            2'd0: tx = {1'b0, px_reg} + 1'b1;
            2'd1: ty = {1'b0, py_reg} - 1'b1;
            2'd2: tx = {1'b0, px_reg} - 1'b1;
            default: ty = {1'b0, py_reg} + 1'b1;
        endcase
        tgt_in   = (tx < {1'b0, side}) && (ty < {1'b0, side});
        prog_inc = rprog_reg + 1'b1;
    end

    assign preq.start = (state_reg == S_MOVE) && (restart_reg || (active_reg && tgt_in));
    assign preq.value = restart_reg ? startv_reg : nval_reg;

    uspw_prime_seq u_prime (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (preq),
        .rsp     (prsp)
    );

    // Walk sequencer with the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            grid_reg   <= COORD_W'(1);
            startv_reg <= 32'd1;
            px_reg     <= '0;
            py_reg     <= '0;
            head_reg   <= '0;
            rlen_reg   <= RUN_W'(1);
            rprog_reg  <= '0;
            nval_reg   <= '0;
            active_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_GRID_SIZE:   grid_reg   <= cfg_data[COORD_W-1:0];
                    CFG_START_VALUE: startv_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        restart_reg <= s_restart;
                        state_reg   <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (restart_reg) begin
                        px_reg     <= side >> 1;
                        py_reg     <= side >> 1;
                        head_reg   <= '0;
                        rlen_reg   <= RUN_W'(1);
                        rprog_reg  <= '0;
                        active_reg <= 1'b1;
                        oval_reg   <= startv_reg;
                        nval_reg   <= startv_reg + 1'b1;
                        state_reg  <= S_TEST;
                    end else if (!active_reg) begin
                        state_reg <= S_IDLE;
                    end else if (!tgt_in) begin
                        active_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end else begin
                        px_reg <= tx[COORD_W-1:0];
                        py_reg <= ty[COORD_W-1:0];
                        if (prog_inc == rlen_reg) begin
                            rprog_reg <= '0;
                            if (head_reg[0]) rlen_reg <= rlen_reg + 1'b1;
                            head_reg <= head_reg + 1'b1;
                        end else begin
                            rprog_reg <= prog_inc;
                        end
                        oval_reg  <= nval_reg;
                        nval_reg  <= nval_reg + 1'b1;
                        state_reg <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (prsp.done) begin
                        oprime_reg <= prsp.prime;
                        olast_reg  <= !tgt_in;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = (state_reg == S_OUT);
    assign m_cell_x     = px_reg;
    assign m_cell_y     = py_reg;
    assign m_cell_value = oval_reg;
    assign m_is_prime   = oprime_reg;
    assign m_last       = olast_reg;
endmodule

// ===== rtl/uspw_checker.sv =====
`include "ulam_spiral_prime_walker_unit_macros.svh"
// Port-level checks on the walker.
module uspw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_cell_value,
    input logic [9:0]  m_cell_x
);
    // No new input word is taken while a result waits.
    `USPW_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // A stalled result keeps its value.
    `USPW_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cell_value))
    // A taken result is followed by the idle, ready state.
    `USPW_ASSERT_NXT(a_ret, aclk, aresetn, m_valid && m_ready, s_ready && !m_valid)
    // Accepting an input word drops ready at once.
    `USPW_ASSERT_NXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A reported column always lies inside the largest grid.
    `USPW_ASSERT_IMP(a_x_range, aclk, aresetn, m_valid, m_cell_x != 10'd1023)
endmodule

bind ulam_spiral_prime_walker_unit uspw_checker u_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_value (m_cell_value),
    .m_cell_x     (m_cell_x)
);
